// File: rtl/core/uvs_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere point package
// Shared constants, register indexes and types of the UV sphere point core.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int MAX_SEGMENTS       = 255;
   localparam int TRIG_FRAC_BITS_DEF = 16;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENTS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 1'b1;

   localparam logic [7:0]  SEGMENTS_RESET = 8'd8;
   localparam logic [15:0] RADIUS_RESET   = 16'd256;

   localparam int DIV_FRAC_BITS       = 33;
   localparam int DIV_STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES = (DIV_FRAC_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
   localparam int DIV_LAT    = DIV_STAGES + 1;

   localparam int TRIG_SLOTS = 6;
   localparam int TRIG_LAT   = 3 + 3 * TRIG_SLOTS + 2;

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

   function automatic int sin_k(input int slot);
      case (slot)
         0: return 110;
         1: return 72;
         2: return 42;
         3: return 20;
         4: return 6;
         default: return 0;
      endcase
   endfunction

   function automatic int cos_k(input int slot);
      case (slot)
         0: return 132;
         1: return 90;
         2: return 56;
         3: return 30;
         4: return 12;
         default: return 2;
      endcase
   endfunction

   typedef struct packed {
      logic        vertex_valid;
      logic        quad_valid;
      logic [15:0] corner;
   } side_type;

endpackage

// File: rtl/core/uvs_req_if.sv
// ----------------------------------------------------------------------------
// UV sphere point request channel
// Carries one grid point beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface uvs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] lat_index;
   logic [7:0] lon_index;

   modport source (output valid, lat_index, lon_index, input ready);
   modport sink   (input valid, lat_index, lon_index, output ready);
endinterface

// File: rtl/core/uvs_rsp_if.sv
// ----------------------------------------------------------------------------
// UV sphere point response channel
// Carries one vertex and quad corner beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface uvs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] pos_x;
   logic signed [16:0] pos_y;
   logic signed [16:0] pos_z;
   logic               vertex_valid;
   logic               quad_valid;
   logic [15:0]        corner_current;
   logic [15:0]        corner_right;
   logic [15:0]        corner_below;
   logic [15:0]        corner_below_right;

   modport source (output valid, pos_x, pos_y, pos_z, vertex_valid, quad_valid,
                   corner_current, corner_right, corner_below, corner_below_right,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, vertex_valid, quad_valid,
                   corner_current, corner_right, corner_below, corner_below_right,
                   output ready);
endinterface

// File: rtl/core/uvs_div.sv
// ----------------------------------------------------------------------------
// UV sphere angle divider
// Pipelined restoring divider giving num/den with one integer and 33 fraction bits.
// ----------------------------------------------------------------------------
module uvs_div
   import uvs_pkg::*;
(
   input  logic                   clock,
   input  logic                   enable,
   input  logic [8:0]             num,
   input  logic [8:0]             den,
   output logic [DIV_FRAC_BITS:0] quot
);

   localparam int RW = 10;
   localparam int QW = DIV_FRAC_BITS + 1;

   logic [RW-1:0] rem_ff [0:DIV_STAGES];
   logic [8:0]    den_ff [0:DIV_STAGES];
   logic [QW-1:0] quo_ff [0:DIV_STAGES];

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff[0] <= den;
         if (num >= den) begin
            rem_ff[0] <= RW'(num) - RW'(den);
            quo_ff[0] <= QW'(1);
         end else begin
            rem_ff[0] <= RW'(num);
            quo_ff[0] <= '0;
         end
      end
   end

   for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_stage
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quo_in;
      logic [RW-1:0] shifted;

      always_comb begin
         rem_in  = rem_ff[g-1];
         quo_in  = quo_ff[g-1];
         shifted = '0;
         for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
            if ((g - 1) * DIV_STEPS_PER_STAGE + s < DIV_FRAC_BITS) begin
               shifted = {rem_in[RW-2:0], 1'b0};
               if (shifted >= RW'(den_ff[g-1])) begin
                  rem_in = shifted - RW'(den_ff[g-1]);
                  quo_in = {quo_in[QW-2:0], 1'b1};
               end else begin
                  rem_in = shifted;
                  quo_in = {quo_in[QW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g] <= rem_in;
            quo_ff[g] <= quo_in;
            den_ff[g] <= den_ff[g-1];
         end
      end
   end

   assign quot = quo_ff[DIV_STAGES];

endmodule

// File: rtl/core/uvs_trig.sv
// ----------------------------------------------------------------------------
// UV sphere sine and cosine pipeline
// Rounds the turn fraction, then evaluates the sine and cosine series in Q30.
// ----------------------------------------------------------------------------
module uvs_trig
   import uvs_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [DIV_FRAC_BITS:0]        quot,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);

   localparam int F  = TRIG_FRAC_BITS;
   localparam int CL = 3 * TRIG_SLOTS;

   logic [DIV_FRAC_BITS:0] u_w;
   logic [1:0]  qa_ff;
   logic [29:0] ra_ff;
   logic [60:0] xb_w;
   logic [1:0]  qb_ff;
   logic [30:0] xb_ff;
   logic [61:0] sq_w;

   logic [1:0]  q_ff  [0:CL];
   logic [30:0] x_ff  [0:CL];
   logic [31:0] x2_ff [0:CL];
   logic [30:0] t_ff  [0:1][1:TRIG_SLOTS];

   logic [61:0] sd_w;
   logic [31:0] sd_ff;
   logic [30:0] cd_ff;
   logic [1:0]  qd_ff;
   logic [31:0] sr_w;
   logic [31:0] cr_w;
   logic [F+1:0] s_v;
   logic [F+1:0] c_v;
   logic [F+1:0] sin_in;
   logic [F+1:0] cos_in;

   assign u_w  = quot + (DIV_FRAC_BITS + 1)'(1);
   assign xb_w = 61'(ra_ff) * 61'(HALF_PI_Q30);
   assign sq_w = 62'(xb_ff) * 62'(xb_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         qa_ff    <= u_w[32:31];
         ra_ff    <= u_w[30:1];
         qb_ff    <= qa_ff;
         xb_ff    <= xb_w[60:30];
         q_ff[0]  <= qb_ff;
         x_ff[0]  <= xb_ff;
         x2_ff[0] <= sq_w[61:30];
         for (int i = 1; i <= CL; i++) begin
            q_ff[i]  <= q_ff[i-1];
            x_ff[i]  <= x_ff[i-1];
            x2_ff[i] <= x2_ff[i-1];
         end
      end
   end

   for (genvar c = 0; c < 2; c++) begin : g_chain
      for (genvar j = 0; j < TRIG_SLOTS; j++) begin : g_slot
         localparam int K = (c == 0) ? sin_k(j) : cos_k(j);
         logic [30:0] t_cur;
         logic [31:0] p1_ff;
         logic [31:0] p2_ff;

         if (j == 0) begin : g_first
            assign t_cur = Q30_ONE;
         end else begin : g_next
            assign t_cur = t_ff[c][j];
         end

         if (K == 0) begin : g_pass
            always_ff @(posedge clock) begin
               if (enable) begin
                  p1_ff         <= 32'(t_cur);
                  p2_ff         <= p1_ff;
                  t_ff[c][j+1]  <= p2_ff[30:0];
               end
            end
         end else begin : g_term
            localparam int LS = 32 + $clog2(K);
            localparam logic [32:0] M = 33'(((64'd1 << LS)) / K);
            logic [62:0] pt_w;
            logic [64:0] pm_w;
            logic [31:0] qe_ff;
            logic [39:0] rem_w;
            logic [31:0] sub_w;

            assign pt_w  = 63'(x2_ff[3*j]) * 63'(t_cur);
            assign pm_w  = 65'(p1_ff) * 65'(M);
            assign rem_w = 40'(p2_ff) - 40'(qe_ff) * 40'(K);
            assign sub_w = (rem_w >= 40'(K)) ? qe_ff + 32'd1 : qe_ff;

            always_ff @(posedge clock) begin
               if (enable) begin
                  p1_ff <= pt_w[61:30];
                  p2_ff <= p1_ff;
                  qe_ff <= 32'(pm_w >> LS);
                  if (sub_w > 32'(Q30_ONE)) begin
                     t_ff[c][j+1] <= '0;
                  end else begin
                     t_ff[c][j+1] <= Q30_ONE - sub_w[30:0];
                  end
               end
            end
         end
      end
   end

   assign sd_w = 62'(x_ff[CL]) * 62'(t_ff[0][TRIG_SLOTS]);
   assign sr_w = (sd_ff + (32'd1 << (29 - F))) >> (30 - F);
   assign cr_w = (32'(cd_ff) + (32'd1 << (29 - F))) >> (30 - F);
   assign s_v  = {1'b0, sr_w[F:0]};
   assign c_v  = {1'b0, cr_w[F:0]};

   always_comb begin
      case (qd_ff)
         2'd0: begin
            sin_in = s_v;
            cos_in = c_v;
         end
         2'd1: begin
            sin_in = c_v;
            cos_in = -s_v;
         end
         2'd2: begin
            sin_in = -s_v;
            cos_in = -c_v;
         end
         default: begin
            sin_in = -c_v;
            cos_in = s_v;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sd_ff <= sd_w[61:30];
         cd_ff <= t_ff[1][TRIG_SLOTS];
         qd_ff <= q_ff[CL];
         sin_o <= $signed(sin_in);
         cos_o <= $signed(cos_in);
      end
   end

endmodule

// File: rtl/core/uv_sphere_mesh_point_core.sv
// ----------------------------------------------------------------------------
// UV sphere mesh point core
// Turns a latitude/longitude grid point into a sphere vertex and quad corners.
// ----------------------------------------------------------------------------
//  Channel  Role    Beat contents
//  req      sink    lat_index, lon_index
//  rsp      source  pos_x/y/z, vertex_valid, quad_valid, four corner indices
//  csr      write   index 0 segments, index 1 radius
//
//  One beat is accepted per cycle unless a beat on rsp is stalled. A result passes
//  through the input register, the 12-stage angle divider, the 23-stage series
//  pipeline and one product stage ahead of the output register.
//  A stall on rsp freezes the whole pipeline; nothing is dropped or repeated.
//  Reset empties the pipeline and loads segments 8 and radius 256.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_point_core
   import uvs_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   uvs_req_if.sink              req,
   uvs_rsp_if.source            rsp,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   localparam int F    = TRIG_FRAC_BITS;
   localparam int LAST = DIV_LAT + TRIG_LAT + 1;

   logic [7:0]  segments_ff;
   logic [15:0] radius_ff;
   logic [7:0]  seg;

   logic        advance;
   logic        valid_ff [0:LAST];
   side_type    side_ff  [0:LAST];
   side_type    side_in;
   logic [16:0] cur_w;

   logic [8:0]  num_th_ff, den_th_ff, num_ph_ff, den_ph_ff;
   logic [DIV_FRAC_BITS:0] quot_th, quot_ph;
   logic signed [F+1:0] sin_th, cos_th, sin_ph, cos_ph;

   logic [F:0]  st_m, ct_m, sp_m, cp_m;
   logic [2*F+1:0] xp_w, zp_w;
   logic [F+1:0] xr_w, zr_w;
   logic [F:0]  xm_ff, ym_ff, zm_ff;
   logic        xn_ff, yn_ff, zn_ff;

   logic [F+16:0] xo_w, yo_w, zo_w;
   logic [16:0] xa_w, ya_w, za_w;
   logic [15:0] below_w;

   logic               rsp_valid_ff;
   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic               vertex_valid_ff, quad_valid_ff;
   logic [15:0]        cur_ff, right_ff, below_ff, below_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         segments_ff <= SEGMENTS_RESET;
         radius_ff   <= RADIUS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SEGMENTS: segments_ff <= csr_wdata[7:0];
            CSR_RADIUS:   radius_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign seg     = (segments_ff > 8'(MAX_SEGMENTS)) ? 8'(MAX_SEGMENTS) : segments_ff;
   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   assign cur_w = 17'(req.lat_index) * (17'(seg) + 17'd1) + 17'(req.lon_index);

   always_comb begin
      side_in.vertex_valid = (seg != 8'd0) && (req.lat_index <= seg) && (req.lon_index <= seg);
      side_in.quad_valid   = (seg != 8'd0) && (req.lat_index < seg) && (req.lon_index < seg);
      side_in.corner       = cur_w[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req.valid;
         for (int i = 1; i <= LAST; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         rsp_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int i = 1; i <= LAST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         num_th_ff <= {1'b0, req.lat_index};
         den_th_ff <= {seg, 1'b0};
         num_ph_ff <= {1'b0, req.lon_index};
         den_ph_ff <= {1'b0, seg};
      end
   end

   uvs_div u_div_th (
      .clock  (clock),
      .enable (advance),
      .num    (num_th_ff),
      .den    (den_th_ff),
      .quot   (quot_th)
   );

   uvs_div u_div_ph (
      .clock  (clock),
      .enable (advance),
      .num    (num_ph_ff),
      .den    (den_ph_ff),
      .quot   (quot_ph)
   );

   uvs_trig #(.TRIG_FRAC_BITS(F)) u_trig_th (
      .clock  (clock),
      .enable (advance),
      .quot   (quot_th),
      .sin_o  (sin_th),
      .cos_o  (cos_th)
   );

   uvs_trig #(.TRIG_FRAC_BITS(F)) u_trig_ph (
      .clock  (clock),
      .enable (advance),
      .quot   (quot_ph),
      .sin_o  (sin_ph),
      .cos_o  (cos_ph)
   );

   assign st_m = sin_th[F+1] ? (F+1)'(0) - sin_th[F:0] : sin_th[F:0];
   assign ct_m = cos_th[F+1] ? (F+1)'(0) - cos_th[F:0] : cos_th[F:0];
   assign sp_m = sin_ph[F+1] ? (F+1)'(0) - sin_ph[F:0] : sin_ph[F:0];
   assign cp_m = cos_ph[F+1] ? (F+1)'(0) - cos_ph[F:0] : cos_ph[F:0];

   assign xp_w = (2*F+2)'(cp_m) * (2*F+2)'(st_m) + ((2*F+2)'(1) << (F - 1));
   assign zp_w = (2*F+2)'(sp_m) * (2*F+2)'(st_m) + ((2*F+2)'(1) << (F - 1));
   assign xr_w = (F+2)'(xp_w >> F);
   assign zr_w = (F+2)'(zp_w >> F);

   always_ff @(posedge clock) begin
      if (advance) begin
         xm_ff <= xr_w[F:0];
         xn_ff <= cos_ph[F+1] ^ sin_th[F+1];
         zm_ff <= zr_w[F:0];
         zn_ff <= sin_ph[F+1] ^ sin_th[F+1];
         ym_ff <= ct_m;
         yn_ff <= cos_th[F+1];
      end
   end

   assign xo_w = (F+17)'(radius_ff) * (F+17)'(xm_ff) + ((F+17)'(1) << (F - 1));
   assign yo_w = (F+17)'(radius_ff) * (F+17)'(ym_ff) + ((F+17)'(1) << (F - 1));
   assign zo_w = (F+17)'(radius_ff) * (F+17)'(zm_ff) + ((F+17)'(1) << (F - 1));
   assign xa_w = xn_ff ? 17'd0 - 17'(xo_w >> F) : 17'(xo_w >> F);
   assign ya_w = yn_ff ? 17'd0 - 17'(yo_w >> F) : 17'(yo_w >> F);
   assign za_w = zn_ff ? 17'd0 - 17'(zo_w >> F) : 17'(zo_w >> F);
   assign below_w = side_ff[LAST].corner + 16'(seg) + 16'd1;

   always_ff @(posedge clock) begin
      if (advance) begin
         vertex_valid_ff <= side_ff[LAST].vertex_valid;
         quad_valid_ff   <= side_ff[LAST].quad_valid;
         if (side_ff[LAST].vertex_valid) begin
            pos_x_ff <= $signed(xa_w);
            pos_y_ff <= $signed(ya_w);
            pos_z_ff <= $signed(za_w);
         end else begin
            pos_x_ff <= '0;
            pos_y_ff <= '0;
            pos_z_ff <= '0;
         end
         if (side_ff[LAST].quad_valid) begin
            cur_ff         <= side_ff[LAST].corner;
            right_ff       <= side_ff[LAST].corner + 16'd1;
            below_ff       <= below_w;
            below_right_ff <= below_w + 16'd1;
         end else begin
            cur_ff         <= '0;
            right_ff       <= '0;
            below_ff       <= '0;
            below_right_ff <= '0;
         end
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.pos_x              = pos_x_ff;
   assign rsp.pos_y              = pos_y_ff;
   assign rsp.pos_z              = pos_z_ff;
   assign rsp.vertex_valid       = vertex_valid_ff;
   assign rsp.quad_valid         = quad_valid_ff;
   assign rsp.corner_current     = cur_ff;
   assign rsp.corner_right       = right_ff;
   assign rsp.corner_below       = below_ff;
   assign rsp.corner_below_right = below_right_ff;

endmodule

// File: rtl/core/uvs_checker.sv
// ----------------------------------------------------------------------------
// UV sphere point checker
// Port-level properties of the response channel, bound to the core.
// ----------------------------------------------------------------------------
module uvs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [16:0] pos_x,
   input logic signed [16:0] pos_y,
   input logic signed [16:0] pos_z,
   input logic               vertex_valid,
   input logic               quad_valid,
   input logic [15:0]        corner_current,
   input logic [15:0]        corner_right
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pos_x) && $stable(corner_current))
      else $error("stalled response beat changed");

   a_quad_in_vertex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && quad_valid |-> vertex_valid)
      else $error("quad flagged without a vertex");

   a_off_grid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !vertex_valid |-> pos_x == 17'sd0 && pos_y == 17'sd0 && pos_z == 17'sd0)
      else $error("position not cleared off the grid");

   a_right_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && quad_valid |-> corner_right == corner_current + 16'd1)
      else $error("right corner does not follow current corner");

endmodule

bind uv_sphere_mesh_point_core uvs_checker u_uvs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .pos_x          (rsp.pos_x),
   .pos_y          (rsp.pos_y),
   .pos_z          (rsp.pos_z),
   .vertex_valid   (rsp.vertex_valid),
   .quad_valid     (rsp.quad_valid),
   .corner_current (rsp.corner_current),
   .corner_right   (rsp.corner_right)
);

// File: tb/sv/uv_sphere_mesh_point_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UV sphere mesh point core testbench
// Streams grid points through the core under several segment and radius
// settings, with random gaps on both channels and one long output stall.
// A fixed-point sphere predictor checks every result field by field.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_point_core_test;
   import uvs_pkg::*;

   typedef struct {
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_z;
      logic               vertex_valid;
      logic               quad_valid;
      logic [15:0]        corner_current;
      logic [15:0]        corner_right;
      logic [15:0]        corner_below;
      logic [15:0]        corner_below_right;
   } vertex_beat_type;

   typedef struct {
      logic [7:0] lat;
      logic [7:0] lon;
   } grid_point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SEGMENTS;
   logic [15:0] csr_wdata = '0;

   uvs_req_if req();
   uvs_rsp_if rsp();

   uv_sphere_mesh_point_core uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   grid_point_type  pending_points[$];
   vertex_beat_type expected_vertices[$];
   logic [7:0]   cur_segments = SEGMENTS_RESET;
   logic [15:0]  cur_radius = RADIUS_RESET;
   int           error_count = 0;
   int           req_gap = 0;
   int           rsp_stall = 0;
   int           rsp_hold = 0;
   int           idle_cycles = 0;
   bit           req_taken = 1'b0;
   bit           burst_mode = 1'b0;

   function automatic int draw_wait();
      if (burst_mode || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic longint unsigned angle_turns(longint unsigned num, longint unsigned den);
      return (((num << 32) + (den >> 1)) / den) & 64'hFFFF_FFFF;
   endfunction

   function automatic longint trig_round(longint unsigned v);
      return longint'((v + (64'd1 << 13)) >> 14);
   endfunction

   function automatic void sin_cos(input longint unsigned u, output longint sn,
                                   output longint cs);
      longint unsigned q, r, x, x2, t, sub;
      longint s, c;
      int sdiv[5];
      int cdiv[6];
      sdiv = '{110, 72, 42, 20, 6};
      cdiv = '{132, 90, 56, 30, 12, 2};
      q = (u >> 30) & 3;
      r = u & ((64'd1 << 30) - 1);
      x = (r * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      for (int i = 0; i < 5; i++) begin
         sub = ((x2 * t) >> 30) / sdiv[i];
         t = (sub > (64'd1 << 30)) ? 0 : (64'd1 << 30) - sub;
      end
      s = trig_round((x * t) >> 30);
      t = 64'd1 << 30;
      for (int i = 0; i < 6; i++) begin
         sub = ((x2 * t) >> 30) / cdiv[i];
         t = (sub > (64'd1 << 30)) ? 0 : (64'd1 << 30) - sub;
      end
      c = trig_round(t);
      case (q)
         0: begin sn = s;  cs = c;  end
         1: begin sn = c;  cs = -s; end
         2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   function automatic longint scale_round(longint a, longint b);
      longint unsigned ma, mb, m;
      bit neg;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb + (64'd1 << 15)) >> 16;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic vertex_beat_type sphere_vertex(logic [7:0] lat, logic [7:0] lon);
      vertex_beat_type v;
      longint st, ct, sp, cp, rad;
      longint unsigned seg, cur, below;
      v = '{default: '0};
      seg = cur_segments;
      rad = cur_radius;
      if (seg == 0)
         return v;
      if (lat <= seg && lon <= seg) begin
         sin_cos(angle_turns(lat, 2 * seg), st, ct);
         sin_cos(angle_turns(lon, seg), sp, cp);
         v.pos_x = 17'(scale_round(rad, scale_round(cp, st)));
         v.pos_y = 17'(scale_round(rad, ct));
         v.pos_z = 17'(scale_round(rad, scale_round(sp, st)));
         v.vertex_valid = 1'b1;
      end
      if (lat < seg && lon < seg) begin
         cur = lat * (seg + 1) + lon;
         below = cur + seg + 1;
         v.quad_valid = 1'b1;
         v.corner_current = 16'(cur);
         v.corner_right = 16'(cur + 1);
         v.corner_below = 16'(below);
         v.corner_below_right = 16'(below + 1);
      end
      return v;
   endfunction

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.lat_index <= '0;
         req.lon_index <= '0;
      end else if (!(req.valid && !req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req.valid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            grid_point_type p;
            p = pending_points.pop_front();
            req.valid <= 1'b1;
            req.lat_index <= p.lat;
            req.lon_index <= p.lon;
            req_gap = draw_wait();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         expected_vertices.insert(expected_vertices.size(),
                                  sphere_vertex(req.lat_index, req.lon_index));
         req_taken = 1'b1;
      end
   end

   // Response ready control.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   task automatic check_field(string name, longint got, longint want);
      if (got != want) begin
         error_count++;
         if (error_count <= 10)
            $display("Mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         vertex_beat_type e;
         rsp_stall = draw_wait();
         if (expected_vertices.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Mismatch: result beat with no request outstanding");
         end else begin
            e = expected_vertices.pop_front();
            check_field("pos_x", rsp.pos_x, e.pos_x);
            check_field("pos_y", rsp.pos_y, e.pos_y);
            check_field("pos_z", rsp.pos_z, e.pos_z);
            check_field("vertex_valid", rsp.vertex_valid, e.vertex_valid);
            check_field("quad_valid", rsp.quad_valid, e.quad_valid);
            check_field("corner_current", rsp.corner_current, e.corner_current);
            check_field("corner_right", rsp.corner_right, e.corner_right);
            check_field("corner_below", rsp.corner_below, e.corner_below);
            check_field("corner_below_right", rsp.corner_below_right,
                        e.corner_below_right);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_SEGMENTS)
         cur_segments = data[7:0];
      else
         cur_radius = data;
   endtask

   task automatic add_point(int lat, int lon);
      grid_point_type p;
      p.lat = 8'(lat);
      p.lon = 8'(lon);
      pending_points.insert(pending_points.size(), p);
   endtask

   function automatic int pick_index();
      int top;
      top = (cur_segments + 1 > 255) ? 255 : cur_segments + 1;
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 255);
      return $urandom_range(0, top);
   endfunction

   task automatic drain();
      wait (pending_points.size() == 0 && !req.valid && expected_vertices.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      int segs[12];
      int rads[12];
      segs = '{0, 1, 255, 255, 2, 3, 0, 0, 0, 0, 0, 0};
      rads = '{0, 65535, 65535, 1, 256, 32768, 0, 0, 0, 0, 0, 0};
      for (int i = 6; i < 12; i++) begin
         segs[i] = (i % 2) ? $urandom_range(1, 255) : $urandom_range(1, 24);
         rads[i] = $urandom_range(0, 65535);
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_point(0, 0);     add_point(8, 8);     add_point(9, 9);
      add_point(255, 255); add_point(8, 0);     add_point(0, 8);
      add_point(7, 7);     add_point(4, 2);     add_point(2, 6);
      add_point(7, 8);     add_point(8, 7);     add_point(9, 0);
      add_point(0, 9);     add_point(170, 85);  add_point(85, 170);
      add_point(1, 1);     add_point(3, 5);     add_point(6, 4);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         write_reg(CSR_SEGMENTS, 16'(segs[ph]));
         write_reg(CSR_RADIUS, 16'(rads[ph]));
         burst_mode = (ph % 3 == 1);
         if (ph == 3)
            rsp_hold = 400;
         for (int n = 0; n < 150; n++)
            add_point(pick_index(), pick_index());
         if (ph == 8) begin
            wait (pending_points.size() == 0 && expected_vertices.size() == 0);
            for (int n = 0; n < 30; n++)
               add_point(pick_index(), pick_index());
         end
         drain();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
